@@ design/ght_pkg.sv @@
`default_nettype none

package ght_pkg;

  // widest slot index for the largest supported table (1024 slots)
  localparam int MaxIdxW = 10;

  // command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCntW      = 2;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_CLOSE     = 2'd2,
    OP_CLOSE_ALL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DENIED  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_WALK_RD,
    BK_WALK_WR
  } back_state_e;

  // classified command as handed from front to back
  typedef struct packed {
    op_e                op;
    logic               bad;
    logic [MaxIdxW-1:0] idx;
    logic [31:0]        gen;
    logic [3:0]         ekind;
    logic [7:0]         rights;
  } cmd_t;

  // one slot of the handle table
  typedef struct packed {
    logic [31:0] gen;
    logic [7:0]  rights;
    logic [3:0]  kind;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

@@ design/ght_front.sv @@
`default_nettype none

module ght_front #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [79:0]        s_axis_tdata_i,
  input  wire logic [1:0]         s_axis_tuser_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  input  wire ght_pkg::back_stat_t stat_i,
  output logic                    push_valid_o,
  input  wire logic               push_ready_i,
  output ght_pkg::cmd_t           push_cmd_o
);

  logic [7:0]    mask_q;
  logic [31:0]   handle_index;
  logic [31:0]   handle_gen;
  logic [3:0]    ekind;
  logic [7:0]    rights;
  ght_pkg::op_e  op;
  logic          out_of_range;

  assign handle_index = s_axis_tdata_i[31:0];
  assign handle_gen   = s_axis_tdata_i[63:32];
  assign ekind        = s_axis_tdata_i[67:64];
  assign rights       = s_axis_tdata_i[75:68];
  assign op           = ght_pkg::op_e'(s_axis_tuser_i);
  assign out_of_range = handle_index >= 32'(SLOT_COUNT);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = push_ready_i && !stat_i.clearing;
  assign push_valid_o    = s_axis_tvalid_i && !stat_i.clearing;

  always_comb begin
    push_cmd_o.op     = op;
    push_cmd_o.idx    = handle_index[ght_pkg::MaxIdxW-1:0];
    push_cmd_o.gen    = handle_gen;
    push_cmd_o.ekind  = ekind;
    push_cmd_o.rights = rights;
    push_cmd_o.bad    = 1'b0;
    case (op)
      ght_pkg::OP_ALLOC: begin
        push_cmd_o.bad    = (ekind == 4'd0);
        push_cmd_o.rights = rights & mask_q;
      end
      ght_pkg::OP_LOOKUP, ght_pkg::OP_CLOSE: begin
        push_cmd_o.bad = out_of_range;
      end
      default: begin
        push_cmd_o.bad = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 8'hFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/ght_queue.sv @@
`default_nettype none

module ght_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire ght_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output ght_pkg::cmd_t      pop_cmd_o
);

  ght_pkg::cmd_t                  buf_q [ght_pkg::QueueDepth];
  logic [ght_pkg::QPtrW-1:0]      wr_ptr_q;
  logic [ght_pkg::QPtrW-1:0]      rd_ptr_q;
  logic [ght_pkg::QCntW-1:0]      cnt_q;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready_o = cnt_q != ght_pkg::QCntW'(ght_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = buf_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/ght_back.sv @@
`default_nettype none

module ght_back #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ght_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output ght_pkg::back_stat_t stat_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         out_status_o,
  output logic [5:0]         out_index_o,
  output logic [31:0]        out_gen_o,
  output logic [3:0]         out_kind_o,
  output logic [7:0]         out_rights_o,
  output logic [6:0]         out_open_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  ght_pkg::entry_t mem [SLOT_COUNT];
  ght_pkg::entry_t rd_q;

  ght_pkg::back_state_e state_q, state_d;
  ght_pkg::cmd_t        cmd_q, cmd_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdxW-1:0]      walk_q, walk_d;
  logic [IdxW-1:0]      clr_q, clr_d;

  logic                 mem_re;
  logic [IdxW-1:0]      mem_raddr;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  ght_pkg::entry_t      mem_wdata;

  logic                 free_found;
  logic [IdxW-1:0]      free_idx;
  logic                 out_free;
  logic                 take;
  logic                 take_imm;
  logic [IdxW-1:0]      cur;

  logic                 load;
  ght_pkg::status_e     res_status;
  logic [31:0]          res_index;
  logic [31:0]          res_gen;
  logic [3:0]           res_kind;
  logic [7:0]           res_rights;
  logic [31:0]          cnt_wide;
  logic                 out_valid_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = (state_q == ght_pkg::BK_IDLE) && cmd_valid_i && out_free;
  assign take_imm = cmd_i.bad || (cmd_i.op == ght_pkg::OP_ALLOC && !free_found);
  assign cur      = cmd_q.idx[IdxW-1:0];

  assign stat_o.clearing = state_q == ght_pkg::BK_CLEAR;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ght_pkg::BK_CLEAR: begin
        if (clr_q == IdxW'(SLOT_COUNT - 1)) begin
          state_d = ght_pkg::BK_IDLE;
        end
      end
      ght_pkg::BK_IDLE: begin
        if (take && !take_imm) begin
          if (cmd_i.op == ght_pkg::OP_CLOSE_ALL) begin
            state_d = ght_pkg::BK_WALK_RD;
          end else begin
            state_d = ght_pkg::BK_EXEC;
          end
        end
      end
      ght_pkg::BK_EXEC: begin
        state_d = ght_pkg::BK_IDLE;
      end
      ght_pkg::BK_WALK_RD: begin
        state_d = ght_pkg::BK_WALK_WR;
      end
      ght_pkg::BK_WALK_WR: begin
        if (walk_q == IdxW'(SLOT_COUNT - 1)) begin
          state_d = ght_pkg::BK_IDLE;
        end else begin
          state_d = ght_pkg::BK_WALK_RD;
        end
      end
      default: begin
        state_d = ght_pkg::BK_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_pop_o  = 1'b0;
    cmd_d      = cmd_q;
    used_d     = used_q;
    count_d    = count_q;
    walk_d     = walk_q;
    clr_d      = clr_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    load       = 1'b0;
    res_status = ght_pkg::ST_OK;
    res_index  = '0;
    res_gen    = '0;
    res_kind   = '0;
    res_rights = '0;
    case (state_q)
      ght_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      ght_pkg::BK_IDLE: begin
        if (take) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (take_imm) begin
            load       = 1'b1;
            res_status = cmd_i.bad ? ght_pkg::ST_INVALID : ght_pkg::ST_FULL;
          end else begin
            case (cmd_i.op)
              ght_pkg::OP_ALLOC: begin
                mem_re    = 1'b1;
                mem_raddr = free_idx;
                cmd_d.idx = ght_pkg::MaxIdxW'(free_idx);
              end
              ght_pkg::OP_LOOKUP, ght_pkg::OP_CLOSE: begin
                mem_re    = 1'b1;
                mem_raddr = cmd_i.idx[IdxW-1:0];
              end
              default: begin
                walk_d = '0;
              end
            endcase
          end
        end
      end
      ght_pkg::BK_EXEC: begin
        load      = 1'b1;
        mem_waddr = cur;
        res_index = 32'(cur);
        case (cmd_q.op)
          ght_pkg::OP_ALLOC: begin
            mem_we           = 1'b1;
            mem_wdata.gen    = rd_q.gen;
            mem_wdata.rights = cmd_q.rights;
            mem_wdata.kind   = cmd_q.ekind;
            used_d[cur]      = 1'b1;
            count_d          = count_q + 1'b1;
            res_gen          = rd_q.gen;
            res_kind         = cmd_q.ekind;
            res_rights       = cmd_q.rights;
          end
          ght_pkg::OP_LOOKUP: begin
            if (!used_q[cur] || rd_q.gen != cmd_q.gen) begin
              res_status = ght_pkg::ST_INVALID;
              res_index  = '0;
            end else if ((rd_q.rights & cmd_q.rights) != cmd_q.rights) begin
              res_status = ght_pkg::ST_DENIED;
              res_index  = '0;
            end else begin
              res_gen    = rd_q.gen;
              res_kind   = rd_q.kind;
              res_rights = rd_q.rights;
            end
          end
          default: begin
            // close: free the slot and bump its generation
            if (!used_q[cur] || rd_q.gen != cmd_q.gen) begin
              res_status = ght_pkg::ST_INVALID;
              res_index  = '0;
            end else begin
              mem_we        = 1'b1;
              mem_wdata.gen = rd_q.gen + 32'd1;
              used_d[cur]   = 1'b0;
              count_d       = count_q - 1'b1;
              res_gen       = rd_q.gen + 32'd1;
            end
          end
        endcase
      end
      ght_pkg::BK_WALK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = walk_q;
      end
      ght_pkg::BK_WALK_WR: begin
        mem_waddr = walk_q;
        if (used_q[walk_q]) begin
          mem_we         = 1'b1;
          mem_wdata.gen  = rd_q.gen + 32'd1;
          used_d[walk_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
        walk_d = walk_q + 1'b1;
        if (walk_q == IdxW'(SLOT_COUNT - 1)) begin
          load = 1'b1;
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  assign cnt_wide = 32'(count_d);

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      out_status_o <= res_status;
      out_index_o  <= res_index[5:0];
      out_gen_o    <= res_gen;
      out_kind_o   <= res_kind;
      out_rights_o <= res_rights;
      out_open_o   <= (cnt_wide > 32'd127) ? 7'd127 : cnt_wide[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ght_pkg::BK_CLEAR;
      used_q      <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/generational_handle_table.sv @@
// generational handle table: SLOT_COUNT slots, each with a kind, a rights mask
// and a 32-bit wrapping generation; handles are (index, generation) pairs
// - s_axis: one operation per beat; tuser carries the operation (alloc,
//   lookup, close, close all), tdata carries the handle and alloc arguments
// - m_axis: exactly one result beat per operation, in order; tuser carries
//   the status, tdata the handle, stored kind/rights and open-slot count
// - cfg: single register write channel (rights bits alloc may store),
//   always ready, write only while no operation is outstanding
// - the front classifies operations (range check, alloc argument check,
//   rights masking) into a two-entry command queue; the back owns the
//   slot memory and in-use bits and produces results
// - a handle error or a full table is answered straight from the idle state;
//   alloc, lookup and close first read the table, then write back; close
//   all reads and writes every slot in turn; a new operation is taken only
//   once the previous one has produced its result
// - lowest free slot comes from a priority encoder over the in-use bits
// - after reset the back sweeps the table memory to zero, during which
//   s_axis is not ready
// - when the m_axis receiver stalls, the result is held in the output
//   register and up to two more operations wait in the command queue
`default_nettype none

module generational_handle_table #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // handle_index[31:0], handle_generation[63:32], entry_kind[67:64],
  // rights_mask[75:68], zero pad [79:76]
  input  wire logic [79:0] s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_index[5:0], out_generation[37:6], found_kind[41:38],
  // found_rights[49:42], open_count[56:50], zero pad [63:57]
  output logic [63:0]      m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]       m_axis_tuser_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);

  ght_pkg::back_stat_t stat;
  logic                push_valid;
  logic                push_ready;
  ght_pkg::cmd_t       push_cmd;
  logic                cmd_valid;
  logic                cmd_pop;
  ght_pkg::cmd_t       cmd;

  logic [1:0]          res_status;
  logic [5:0]          res_index;
  logic [31:0]         res_gen;
  logic [3:0]          res_kind;
  logic [7:0]          res_rights;
  logic [6:0]          res_open;

  // front: classify and mask
  ght_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .stat_i         (stat),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_cmd_o     (push_cmd)
  );

  // decouples front from back
  ght_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (cmd_valid),
    .pop_i       (cmd_pop),
    .pop_cmd_o   (cmd)
  );

  // back: table memory, in-use bits, result register
  ght_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(res_status),
    .out_index_o (res_index),
    .out_gen_o   (res_gen),
    .out_kind_o  (res_kind),
    .out_rights_o(res_rights),
    .out_open_o  (res_open)
  );

  assign m_axis_tuser_o = res_status;
  assign m_axis_tdata_o = {7'd0, res_open, res_rights, res_kind, res_gen, res_index};

  // an error result carries no handle, kind or rights
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != 2'(ght_pkg::ST_OK)) |->
      (m_axis_tdata_o[49:0] == 50'd0))
    else $error("error result with nonzero payload");

  // no command leaves the queue during the memory clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> (!cmd_pop && !s_axis_tready_o))
    else $error("command taken during clearing sweep");

  // no result appears while clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !m_axis_tvalid_o)
    else $error("result during clearing sweep");

  // open count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[56:50]) <= 32'(SLOT_COUNT)))
    else $error("open count beyond table size");

endmodule

`default_nettype wire
